// ===== rtl/core/random_projection_lsh_bucketer_core_assert.svh =====
// Assertion macros shared by the bucketer core modules.
// No dependencies; take in with `include after the timescale line.
`ifndef RANDOM_PROJECTION_LSH_BUCKETER_CORE_ASSERT_SVH
`define RANDOM_PROJECTION_LSH_BUCKETER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RPLSH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RPLSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rplsh_pkg.sv =====
// Package for the LSH bucketer core: widths, codes, limits and shared types.
// No dependencies.
`timescale 1ns / 1ps

package rplsh_pkg;

    localparam int NUM_PLANES_DEF = 8;
    localparam int NUM_FEATS_DEF  = 64;

    localparam int W_W       = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 38;
    localparam int SIG_W     = 8;
    localparam int CNT_W     = 20;
    localparam int COST_W    = 40;
    localparam int HIST_DEPTH = 256;
    localparam int FC_W      = 7;
    localparam int PC_W      = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 20'hF_FFFF;
    localparam logic [COST_W-1:0] COST_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [FC_W-1:0]   FC_RESET = 7'd64;
    localparam logic [PC_W-1:0]   PC_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_FEATURE = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef struct packed {
        logic             valid;
        logic             is_clear;
        logic [SIG_W-1:0] sig;
    } t_sig_token;

endpackage

// ===== rtl/core/rplsh_in_if.sv =====
// Input channel of the LSH bucketer core: valid, ready and one input item.
// Depends on rplsh_pkg for field widths.
`timescale 1ns / 1ps

interface rplsh_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          operation;
    logic [2:0]                          plane_select;
    logic [5:0]                          feature_select;
    logic signed [rplsh_pkg::W_W-1:0]    weight;
    logic signed [rplsh_pkg::W_W-1:0]    feature_value;

    modport source (
        output valid, operation, plane_select, feature_select, weight, feature_value,
        input  ready
    );
    modport sink (
        input  valid, operation, plane_select, feature_select, weight, feature_value,
        output ready
    );
endinterface

// ===== rtl/core/rplsh_out_if.sv =====
// Result channel of the LSH bucketer core: valid, ready and one result item.
// Depends on rplsh_pkg for field widths.
`timescale 1ns / 1ps

interface rplsh_out_if;
    logic                              valid;
    logic                              ready;
    logic [rplsh_pkg::SIG_W-1:0]       signature;
    logic [rplsh_pkg::CNT_W-1:0]       vector_index;
    logic [rplsh_pkg::CNT_W-1:0]       bucket_count;
    logic [rplsh_pkg::COST_W-1:0]      collision_cost;

    modport source (
        output valid, signature, vector_index, bucket_count, collision_cost,
        input  ready
    );
    modport sink (
        input  valid, signature, vector_index, bucket_count, collision_cost,
        output ready
    );
endinterface

// ===== rtl/core/rplsh_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rplsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rplsh_mac.sv =====
// Weight banks, element counter and per-plane multiply-accumulate lanes.
// Emits a signature or clear token per finished vector. Depends on rplsh_pkg,
// rplsh_ram and the assertion header.
`timescale 1ns / 1ps
`include "random_projection_lsh_bucketer_core_assert.svh"

module rplsh_mac #(
    parameter int NUM_PLANES = rplsh_pkg::NUM_PLANES_DEF,
    parameter int NUM_FEATS  = rplsh_pkg::NUM_FEATS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_accept,
    input  logic [1:0]                        i_operation,
    input  logic [2:0]                        i_plane_select,
    input  logic [5:0]                        i_feature_select,
    input  logic signed [rplsh_pkg::W_W-1:0]  i_weight,
    input  logic signed [rplsh_pkg::W_W-1:0]  i_feature_value,
    input  logic [rplsh_pkg::FC_W-1:0]        i_feature_count,
    input  logic [rplsh_pkg::PC_W-1:0]        i_plane_count,
    output rplsh_pkg::t_sig_token             o_token
);

    localparam int AW  = (NUM_FEATS > 1) ? $clog2(NUM_FEATS) : 1;
    localparam int CW  = ($clog2(NUM_FEATS + 1) > rplsh_pkg::FC_W) ?
                         $clog2(NUM_FEATS + 1) : rplsh_pkg::FC_W;
    localparam int PW  = ($clog2(NUM_PLANES + 1) > rplsh_pkg::PC_W) ?
                         $clog2(NUM_PLANES + 1) : rplsh_pkg::PC_W;
    localparam int SW  = (NUM_PLANES > rplsh_pkg::SIG_W) ? NUM_PLANES : rplsh_pkg::SIG_W;
    localparam int ACC_W  = rplsh_pkg::ACC_W;
    localparam int PROD_W = rplsh_pkg::PROD_W;
    localparam logic [CW-1:0] NF_MAX = CW'(NUM_FEATS);
    localparam logic [PW-1:0] NP_MAX = PW'(NUM_PLANES);

    rplsh_pkg::t_op op;
    logic           is_load_ok;
    logic           is_elem;
    logic           is_clear;
    logic [CW-1:0]  fc_ext;
    logic [CW-1:0]  nf;
    logic [PW-1:0]  pc_ext;
    logic [PW-1:0]  np;
    logic [CW-1:0]  cnt_next;
    logic           last;
    logic [AW-1:0]  r_cnt;
    logic [AW-1:0]  n_cnt;

    logic                             r_s1_valid;
    logic                             r_s1_clear;
    logic                             r_s1_last;
    logic signed [rplsh_pkg::W_W-1:0] r_s1_x;
    logic                             r_s2_valid;
    logic                             r_s2_clear;
    logic                             r_s2_last;

    logic signed [rplsh_pkg::W_W-1:0] w_rd  [NUM_PLANES];
    logic signed [PROD_W-1:0]         r_prod[NUM_PLANES];
    logic [ACC_W-1:0]                 r_acc [NUM_PLANES];
    logic [ACC_W-1:0]                 n_acc [NUM_PLANES];
    logic [NUM_PLANES-1:0]            nonneg;
    logic [SW-1:0]                    sig_wide;
    rplsh_pkg::t_sig_token            r_tok;

    always_comb begin
        op         = rplsh_pkg::t_op'(i_operation);
        is_load_ok = (int'(i_plane_select) < NUM_PLANES) &&
                     (int'(i_feature_select) < NUM_FEATS);
        is_elem    = 1'b0;
        is_clear   = 1'b0;
        unique case (op)
            rplsh_pkg::OP_FEATURE: is_elem  = 1'b1;
            rplsh_pkg::OP_CLEAR:   is_clear = 1'b1;
            default:               is_elem  = 1'b0;
        endcase

        fc_ext = CW'(i_feature_count);
        if (fc_ext == '0) begin
            nf = CW'(1);
        end else if (fc_ext > NF_MAX) begin
            nf = NF_MAX;
        end else begin
            nf = fc_ext;
        end
        pc_ext = PW'(i_plane_count);
        if (pc_ext == '0) begin
            np = PW'(1);
        end else if (pc_ext > NP_MAX) begin
            np = NP_MAX;
        end else begin
            np = pc_ext;
        end

        cnt_next = CW'(r_cnt) + CW'(1);
        last     = (cnt_next >= nf);
        n_cnt    = r_cnt;
        if (i_accept && is_clear) begin
            n_cnt = '0;
        end else if (i_accept && is_elem) begin
            n_cnt = last ? '0 : cnt_next[AW-1:0];
        end
    end

    // one weight bank per plane, addressed by feature position
    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
        logic             lane_we;
        logic [rplsh_pkg::W_W-1:0] lane_rd;

        assign lane_we = i_accept && (op == rplsh_pkg::OP_LOAD) && is_load_ok &&
                         (int'(i_plane_select) == g);

        rplsh_ram #(
            .WIDTH(rplsh_pkg::W_W),
            .DEPTH(NUM_FEATS)
        ) u_wram (
            .i_clk   (i_clk),
            .i_we    (lane_we),
            .i_waddr (AW'(i_feature_select)),
            .i_wdata (i_weight),
            .i_re    (i_accept && is_elem),
            .i_raddr (r_cnt),
            .o_rdata (lane_rd)
        );

        assign w_rd[g] = $signed(lane_rd);
    end

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            // hold planes beyond the configured count
            if (i < int'(np)) begin
                n_acc[i] = r_acc[i] + {{(ACC_W - PROD_W){r_prod[i][PROD_W-1]}}, r_prod[i]};
            end else begin
                n_acc[i] = r_acc[i];
            end
            nonneg[NUM_PLANES-1-i] = ~n_acc[i][ACC_W-1];
        end
        sig_wide = SW'(nonneg) >> (NP_MAX - np);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_tok      <= '0;
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
            if (i_en) begin
                r_s1_valid <= i_accept && (is_elem || is_clear);
                r_s2_valid <= r_s1_valid;
                r_tok.valid    <= r_s2_valid && (r_s2_clear || r_s2_last);
                r_tok.is_clear <= r_s2_clear;
                r_tok.sig      <= sig_wide[rplsh_pkg::SIG_W-1:0];
                if (r_s2_valid) begin
                    for (int i = 0; i < NUM_PLANES; i++) begin
                        r_acc[i] <= (r_s2_clear || r_s2_last) ? '0 : n_acc[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_clear <= is_clear;
            r_s1_last  <= last;
            r_s1_x     <= i_feature_value;
            r_s2_clear <= r_s1_clear;
            r_s2_last  <= r_s1_last;
            for (int i = 0; i < NUM_PLANES; i++) begin
                r_prod[i] <= r_s1_x * w_rd[i];
            end
        end
    end

    assign o_token = r_tok;

    `RPLSH_ASSERT_NEXT(a_cnt_wrap, i_clk, i_rst_n, i_accept && is_elem && last,
        r_cnt == '0, "element counter did not wrap at vector end")
    `RPLSH_ASSERT_NEXT(a_cnt_clear, i_clk, i_rst_n, i_accept && is_clear,
        r_cnt == '0, "element counter not cleared")
    `RPLSH_ASSERT_NEXT(a_acc_clear, i_clk, i_rst_n,
        i_en && r_s2_valid && (r_s2_last || r_s2_clear),
        r_acc[0] == '0 && r_tok.valid, "accumulator not cleared after vector end")

endmodule

// ===== rtl/core/rplsh_hist.sv =====
// Bucket histogram with read-modify-write and forwarding, running cost,
// vector counter and output register. Depends on rplsh_pkg, rplsh_ram and
// the assertion header.
`timescale 1ns / 1ps
`include "random_projection_lsh_bucketer_core_assert.svh"

module rplsh_hist (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rplsh_pkg::t_sig_token            i_token,
    input  logic                             i_out_ready,
    output logic                             o_en,
    output logic                             o_out_valid,
    output logic [rplsh_pkg::SIG_W-1:0]      o_signature,
    output logic [rplsh_pkg::CNT_W-1:0]      o_vector_index,
    output logic [rplsh_pkg::CNT_W-1:0]      o_bucket_count,
    output logic [rplsh_pkg::COST_W-1:0]     o_collision_cost
);

    localparam int CNT_W  = rplsh_pkg::CNT_W;
    localparam int COST_W = rplsh_pkg::COST_W;

    rplsh_pkg::t_sig_token            r_s4;
    logic [CNT_W-1:0]                 rdata;
    logic                             r_fwd_hit;
    logic [CNT_W-1:0]                 r_fwd_data;
    logic [rplsh_pkg::HIST_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]                 r_vcnt;
    logic [COST_W-1:0]                r_cost;
    logic                             r_out_valid;
    logic [rplsh_pkg::SIG_W-1:0]      r_out_sig;
    logic [CNT_W-1:0]                 r_out_index;
    logic [CNT_W-1:0]                 r_out_count;
    logic [COST_W-1:0]                r_out_cost;

    logic             s4_vec;
    logic             s4_clr;
    logic             en;
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] nc;
    logic [CNT_W:0]   add;
    logic [COST_W:0]  sum;
    logic [COST_W-1:0] n_cost;

    always_comb begin
        s4_vec = r_s4.valid && !r_s4.is_clear;
        s4_clr = r_s4.valid && r_s4.is_clear;
        en     = !(s4_vec && r_out_valid && !i_out_ready);
        if (r_fwd_hit) begin
            c = r_fwd_data;
        end else if (r_valid[r_s4.sig]) begin
            c = rdata;
        end else begin
            c = '0;
        end
        nc     = (c >= rplsh_pkg::CNT_MAX) ? rplsh_pkg::CNT_MAX : c + CNT_W'(1);
        add    = {c, 1'b1};
        sum    = {1'b0, r_cost} + (COST_W + 1)'(add);
        n_cost = (sum > {1'b0, rplsh_pkg::COST_MAX}) ? rplsh_pkg::COST_MAX :
                 sum[COST_W-1:0];
    end

    rplsh_ram #(
        .WIDTH(CNT_W),
        .DEPTH(rplsh_pkg::HIST_DEPTH)
    ) u_hram (
        .i_clk   (i_clk),
        .i_we    (en && s4_vec),
        .i_waddr (r_s4.sig),
        .i_wdata (nc),
        .i_re    (en && i_token.valid && !i_token.is_clear),
        .i_raddr (i_token.sig),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4        <= '0;
            r_fwd_hit   <= 1'b0;
            r_valid     <= '0;
            r_vcnt      <= '0;
            r_cost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_s4      <= i_token;
                // forward the count being written to a read of the same bucket
                r_fwd_hit <= s4_vec && (r_s4.sig == i_token.sig);
                if (s4_clr) begin
                    r_valid <= '0;
                    r_vcnt  <= '0;
                    r_cost  <= '0;
                end else if (s4_vec) begin
                    r_valid[r_s4.sig] <= 1'b1;
                    r_cost <= n_cost;
                    if (r_vcnt != rplsh_pkg::CNT_MAX) begin
                        r_vcnt <= r_vcnt + CNT_W'(1);
                    end
                end
            end
            if (en && s4_vec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd_data <= nc;
        end
        if (en && s4_vec) begin
            r_out_sig   <= r_s4.sig;
            r_out_index <= r_vcnt;
            r_out_count <= nc;
            r_out_cost  <= n_cost;
        end
    end

    assign o_en             = en;
    assign o_out_valid      = r_out_valid;
    assign o_signature      = r_out_sig;
    assign o_vector_index   = r_out_index;
    assign o_bucket_count   = r_out_count;
    assign o_collision_cost = r_out_cost;

    `RPLSH_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, en && s4_vec,
        r_out_valid, "finished vector did not reach output register")
    `RPLSH_ASSERT_NEXT(a_cost_mono, i_clk, i_rst_n, !(en && s4_clr),
        r_cost >= $past(r_cost), "collision cost decreased without clear")
    `RPLSH_ASSERT_SAME(a_count_nz, i_clk, i_rst_n, r_out_valid,
        r_out_count != '0, "result bucket count is zero")

endmodule

// ===== rtl/core/random_projection_lsh_bucketer_core.sv =====
// Top level of the random-hyperplane LSH bucketer core.
// Depends on rplsh_pkg, rplsh_in_if, rplsh_out_if, rplsh_mac and rplsh_hist.
//
// Usage:
//   i_in carries loads (operation 0), feature elements (1) and clears (2);
//   o_out carries one result per finished vector. A transfer takes place on
//   a rising edge with valid and ready high. On the config port the user
//   must write feature_count (index 0) and plane_count (index 1) only while
//   the block idles; the block itself does not enforce this. Throughput:
//   one input item per cycle while i_in.ready stays high, set by the
//   per-plane multiply-accumulate lanes and the histogram read-modify-write,
//   which forwards a count still being written to a read of the
//   same bucket. The last element of a vector passes weight read (at the
//   transfer), multiply, accumulate, histogram read and histogram update.
//   Reset: counters, accumulators and histogram valid bits clear at once;
//   the weight banks keep whatever they hold and must be loaded.
//   Stall: while a result waits on o_out, items keep entering until the
//   next result reaches the histogram update stage; then i_in.ready drops.
`timescale 1ns / 1ps

module random_projection_lsh_bucketer_core #(
    parameter int NUM_PLANES = rplsh_pkg::NUM_PLANES_DEF,
    parameter int NUM_FEATS  = rplsh_pkg::NUM_FEATS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rplsh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rplsh_pkg::CFG_W-1:0]        i_cfg_data,
    rplsh_in_if.sink                           i_in,
    rplsh_out_if.source                        o_out
);

    logic [rplsh_pkg::FC_W-1:0] r_feature_count;
    logic [rplsh_pkg::PC_W-1:0] r_plane_count;
    logic                       en;
    logic                       accept;
    rplsh_pkg::t_sig_token      token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= rplsh_pkg::FC_RESET;
            r_plane_count   <= rplsh_pkg::PC_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rplsh_pkg::CFG_FEATURE_COUNT) begin
                r_feature_count <= i_cfg_data[rplsh_pkg::FC_W-1:0];
            end else if (i_cfg_index == rplsh_pkg::CFG_PLANE_COUNT) begin
                r_plane_count <= i_cfg_data[rplsh_pkg::PC_W-1:0];
            end
        end
    end

    assign i_in.ready = en;
    assign accept     = i_in.valid && en;

    rplsh_mac #(
        .NUM_PLANES(NUM_PLANES),
        .NUM_FEATS (NUM_FEATS)
    ) u_mac (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_accept         (accept),
        .i_operation      (i_in.operation),
        .i_plane_select   (i_in.plane_select),
        .i_feature_select (i_in.feature_select),
        .i_weight         (i_in.weight),
        .i_feature_value  (i_in.feature_value),
        .i_feature_count  (r_feature_count),
        .i_plane_count    (r_plane_count),
        .o_token          (token)
    );

    rplsh_hist u_hist (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_token          (token),
        .i_out_ready      (o_out.ready),
        .o_en             (en),
        .o_out_valid      (o_out.valid),
        .o_signature      (o_out.signature),
        .o_vector_index   (o_out.vector_index),
        .o_bucket_count   (o_out.bucket_count),
        .o_collision_cost (o_out.collision_cost)
    );

endmodule

// ===== tb/rplsh_bucket_checker.sv =====
// Scoreboard for the LSH bucketer core: watches config writes and both channels,
// predicts each signature, bucket count and collision cost, and compares results.
// Depends on rplsh_pkg, rplsh_in_if and rplsh_out_if.
`timescale 1ns / 1ps

module rplsh_bucket_checker
    import rplsh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    rplsh_in_if                  i_in,
    rplsh_out_if                 i_out,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [SIG_W-1:0]  sig;
        logic [CNT_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic [COST_W-1:0] cost;
    } t_bucket_result;

    logic signed [W_W-1:0]   plane_w     [NUM_PLANES_DEF][NUM_FEATS_DEF];
    logic signed [ACC_W-1:0] lane_acc    [NUM_PLANES_DEF];
    logic [CNT_W-1:0]        bucket_hist [HIST_DEPTH];
    logic [FC_W-1:0]         feat_count_reg;
    logic [PC_W-1:0]         plane_count_reg;
    int                      elem_seen;
    logic [CNT_W-1:0]        vec_seen;
    logic [COST_W-1:0]       cost_sum;
    t_bucket_result          expected_buckets [$];
    int                      fail_total = 0;

    function automatic int clamp_count(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic clear_vector();
        foreach (lane_acc[i]) lane_acc[i] = '0;
        elem_seen = 0;
    endtask

    task automatic clear_counts();
        foreach (bucket_hist[i]) bucket_hist[i] = '0;
        vec_seen = '0;
        cost_sum = '0;
        clear_vector();
    endtask

    task automatic project_element(input logic signed [W_W-1:0] x);
        int                       nf;
        int                       np;
        int                       pos;
        logic signed [PROD_W-1:0] prod;
        logic [SIG_W-1:0]         sig;
        logic [CNT_W-1:0]         old_cnt;
        logic [COST_W:0]          cost_next;
        t_bucket_result           res;
        nf  = clamp_count(int'(feat_count_reg), NUM_FEATS_DEF);
        np  = clamp_count(int'(plane_count_reg), NUM_PLANES_DEF);
        pos = (elem_seen >= NUM_FEATS_DEF) ? NUM_FEATS_DEF - 1 : elem_seen;
        for (int i = 0; i < np; i++) begin
            prod = x * plane_w[i][pos];
            lane_acc[i] = lane_acc[i] + prod;
        end
        elem_seen++;
        if (elem_seen >= nf) begin
            sig = '0;
            for (int i = 0; i < np; i++) begin
                sig = {sig[SIG_W-2:0], ~lane_acc[i][ACC_W-1]};
            end
            old_cnt   = bucket_hist[sig];
            cost_next = {1'b0, cost_sum} + {old_cnt, 1'b1};
            cost_sum  = (cost_next > {1'b0, COST_MAX}) ? COST_MAX : cost_next[COST_W-1:0];
            bucket_hist[sig] = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + 1'b1;
            res.sig  = sig;
            res.idx  = vec_seen;
            res.cnt  = bucket_hist[sig];
            res.cost = cost_sum;
            expected_buckets.insert(expected_buckets.size(), res);
            if (vec_seen != CNT_MAX) vec_seen++;
            clear_vector();
        end
    endtask

    task automatic check_result();
        t_bucket_result got;
        t_bucket_result want;
        got.sig  = i_out.signature;
        got.idx  = i_out.vector_index;
        got.cnt  = i_out.bucket_count;
        got.cost = i_out.collision_cost;
        if (expected_buckets.size() == 0) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
                $display("unexpected result: sig %0d idx %0d cnt %0d cost %0d",
                         got.sig, got.idx, got.cnt, got.cost);
        end else begin
            want = expected_buckets.pop_front();
            if (got.sig !== want.sig || got.idx !== want.idx ||
                got.cnt !== want.cnt || got.cost !== want.cost) begin
                fail_total++;
                if (fail_total <= MAX_REPORTS) begin
                    $display("mismatch: expected sig %0d idx %0d cnt %0d cost %0d",
                             want.sig, want.idx, want.cnt, want.cost);
                    $display("          got      sig %0d idx %0d cnt %0d cost %0d",
                             got.sig, got.idx, got.cnt, got.cost);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            feat_count_reg  = FC_RESET;
            plane_count_reg = PC_RESET;
            clear_counts();
            expected_buckets.delete();
        end else begin
            if (i_out.valid && i_out.ready) check_result();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FEATURE_COUNT: feat_count_reg  = i_cfg_data[FC_W-1:0];
                    CFG_PLANE_COUNT:   plane_count_reg = i_cfg_data[PC_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.operation)
                    OP_LOAD:    plane_w[i_in.plane_select][i_in.feature_select] = i_in.weight;
                    OP_FEATURE: project_element(i_in.feature_value);
                    OP_CLEAR:   clear_counts();
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_buckets.size();
    end

endmodule

// ===== tb/random_projection_lsh_bucketer_core_test.sv =====
// Top of the LSH bucketer core testbench: clock, reset, weight loads, feature
// streams and config phases, with random idling on both channels and a watchdog.
// Depends on rplsh_pkg, the channel interfaces, the core and rplsh_bucket_checker.
`timescale 1ns / 1ps

module random_projection_lsh_bucketer_core_test;
    import rplsh_pkg::*;

    localparam int         HALF_PERIOD   = 4;
    localparam int         RESET_CYCLES  = 6;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         IDLE_PCT      = 20;
    localparam int         PHASES        = 8;
    localparam int         WIDE_PLANES   = 2;
    localparam int         NARROW_FEATS  = 16;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 quiet_run;
    int                   fail_count;
    int                   pending_results;

    int phase_fc  [PHASES] = '{4, 1, 127, 0, 3, 16, 2, 9};
    int phase_pc  [PHASES] = '{8, 1, 2, 0, 2, 122, 3, 5};
    int phase_len [PHASES] = '{25, 20, 80, 15, 30, 35, 15, 15};

    rplsh_in_if  in_ch ();
    rplsh_out_if out_ch ();

    random_projection_lsh_bucketer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    rplsh_bucket_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic signed [W_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return r[W_W-1:0];
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [2:0] plane,
                             input logic [5:0] feat, input logic signed [W_W-1:0] w,
                             input logic signed [W_W-1:0] x);
        while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.operation      <= op;
        in_ch.plane_select   <= plane;
        in_ch.feature_select <= feat;
        in_ch.weight         <= w;
        in_ch.feature_value  <= x;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_element(input logic signed [W_W-1:0] x);
        send_item(OP_FEATURE, 3'($urandom_range(7)), 6'($urandom_range(63)), pick_sample(), x);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] fc, input logic [CFG_W-1:0] pc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FEATURE_COUNT;
        cfg_data  <= fc;
        @(posedge i_clk);
        cfg_index <= CFG_PLANE_COUNT;
        cfg_data  <= pc;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 80)
                send_element(pick_sample());
            else if (r < 95)
                send_item(OP_LOAD, 3'($urandom_range(7)), 6'($urandom_range(63)),
                          pick_sample(), pick_sample());
            else if (r < 97)
                send_item(OP_CLEAR, 3'($urandom_range(7)), 6'($urandom_range(63)),
                          pick_sample(), pick_sample());
            else
                send_item(OP_UNUSED, 3'($urandom_range(7)), 6'($urandom_range(63)),
                          pick_sample(), pick_sample());
            if ($urandom_range(199) == 0) drain();
        end
    endtask

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_FEATURE_COUNT;
        cfg_data             = '0;
        quiet_run            = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.operation      = OP_LOAD;
        in_ch.plane_select   = '0;
        in_ch.feature_select = '0;
        in_ch.weight         = '0;
        in_ch.feature_value  = '0;
        out_ch.ready         = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load every feature of the low planes and the low features of the rest;
        // long vectors below run only on the low planes
        for (int p = 0; p < NUM_PLANES_DEF; p++) begin
            for (int f = 0; f < NUM_FEATS_DEF; f++) begin
                if (p < WIDE_PLANES || f < NARROW_FEATS)
                    send_item(OP_LOAD, 3'(p), 6'(f), pick_sample(), pick_sample());
            end
        end

        drain();
        write_config(7'd1, 7'd1);
        send_item(OP_LOAD, 3'd0, 6'd0, 16'sh8000, 16'sh0000);
        send_element(16'sh7FFF);
        send_element(16'sh8000);
        send_element(16'sh0000);
        send_item(OP_LOAD, 3'd7, 6'd63, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_LOAD, 3'd0, 6'd0, 16'sh7FFF, 16'sh8000);
        send_item(OP_UNUSED, 3'd7, 6'd63, 16'sh8000, 16'sh7FFF);
        send_element(16'sh7FFF);
        send_item(OP_CLEAR, 3'd7, 6'd63, 16'shFFFF, 16'shFFFF);
        send_element(16'shFFFF);

        drain();
        write_config(7'd0, 7'd0);
        send_element(16'sh0005);

        drain();
        write_config(7'd10, 7'd8);
        repeat (3) send_element(pick_sample());
        // lower the element count under a partial vector
        drain();
        write_config(7'd2, 7'd8);
        send_element(pick_sample());

        drain();
        write_config(7'd2, 7'd9);
        send_element(16'sh8000);
        send_element(16'sh7FFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            quiet_run <= (ph == 2);
            write_config(CFG_W'(phase_fc[ph]), CFG_W'(phase_pc[ph]));
            run_phase(phase_len[ph]);
        end

        drain();
        if (fail_count == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
